// ===== hw/rtl/aclr_pkg.sv =====
package aclr_pkg;

    // Default geometry
    localparam int WAYS_DEF       = 8;
    localparam int KEY_BITS_DEF   = 32;
    localparam int DATA_BITS_DEF  = 32;
    localparam int STAMP_BITS_DEF = 32;

    // Fixed field widths
    localparam int SLOT_BITS = 3;
    localparam int SEED_BITS = 16;

    // Commands
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // Replacement policies
    localparam logic POLICY_LRU    = 1'b0;
    localparam logic POLICY_RANDOM = 1'b1;

    // Register indexes (byte address bit 2)
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_SEED   = 1'b1;

    // Victim generator: Galois LFSR, right shift
    localparam logic [SEED_BITS-1:0] LFSR_TAPS  = 16'hB400;
    localparam logic [SEED_BITS-1:0] LFSR_RESET = 16'h0001;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_VICTIM,
        ST_FETCH,
        ST_UPDATE
    } t_state;

    // Controls from the sequencer to the victim generator
    typedef struct packed {
        logic seed_load;
        logic start;
        logic step;
    } t_victim_ctrl;

endpackage

// ===== hw/rtl/aclr_victim.sv =====
module aclr_victim #(
    parameter int WAYS = aclr_pkg::WAYS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  aclr_pkg::t_victim_ctrl           i_ctrl,
    input  logic [aclr_pkg::SEED_BITS-1:0]   i_seed,
    output logic                             o_busy,
    output logic [$clog2(WAYS)-1:0]          o_pick
);
    import aclr_pkg::*;

    localparam int IW     = $clog2(WAYS);
    localparam int PROD_W = SEED_BITS + 32;
    // Way count reciprocal scaled by 2^32, rounded up; exact for any 16-bit value
    localparam logic [31:0] RECIP =
        32'(((64'd1 << 32) + 64'(WAYS) - 64'd1) / 64'(WAYS));
    localparam logic [SEED_BITS-1:0] WAYS_S = SEED_BITS'(WAYS);

    logic [SEED_BITS-1:0] r_lfsr;
    logic [SEED_BITS-1:0] r_shift;
    logic [SEED_BITS-1:0] r_quot;
    logic [IW-1:0]        r_rem;
    logic [1:0]           r_cnt;
    logic [PROD_W-1:0]    quot_prod;
    logic [SEED_BITS-1:0] quot_back;
    logic [SEED_BITS-1:0] rem_full;

    // Load the seed, or advance one Galois step after a random pick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= LFSR_RESET;
        end else if (i_ctrl.seed_load) begin
            r_lfsr <= (i_seed == '0) ? LFSR_RESET : i_seed;
        end else if (i_ctrl.step) begin
            r_lfsr <= (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : '0);
        end
    end

    // Quotient by reciprocal multiply, then remainder by multiply back and subtract
    always_comb begin
        quot_prod = PROD_W'(r_shift) * PROD_W'(RECIP);
        quot_back = r_quot * WAYS_S;
        rem_full  = r_shift - quot_back;
    end

    // Two steps: quotient, then remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctrl.start) begin
            r_cnt <= 2'd2;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_shift <= r_lfsr;
        end else begin
            if (r_cnt == 2'd2) begin
                r_quot <= quot_prod[PROD_W-1:32];
            end
            if (r_cnt == 2'd1) begin
                r_rem <= rem_full[IW-1:0];
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_pick = r_rem;

endmodule

// ===== hw/rtl/assoc_cache_lru_random.sv =====
// Fully associative cache of WAYS keyed entries. A lookup (tuser 0) returns the payload of
// the lowest valid slot whose key matches and refreshes its stamp; an insert (tuser 1) fills
// the lowest empty slot or, when all are full, replaces a victim chosen by replacement_policy
// (least recently used stamp, lowest index on ties, or a 16-bit LFSR modulo WAYS) and reports
// the replaced entry. Inserts do not check for duplicate keys. Stamps come from a saturating
// access counter. The keys, payloads and stamps sit in single-read-port memories that are
// walked one slot per cycle through a registered read, followed by an update state. An
// insert into a full cache adds a victim pick and a victim read under either policy; the
// random pick comes from a reciprocal-multiply modulo unit started at the transfer, and the
// victim pick waits until that unit is done. Input is accepted only while no item is in work;
// a finished result waits in the output register.
module assoc_cache_lru_random #(
    parameter int WAYS       = aclr_pkg::WAYS_DEF,
    parameter int KEY_BITS   = aclr_pkg::KEY_BITS_DEF,
    parameter int DATA_BITS  = aclr_pkg::DATA_BITS_DEF,
    parameter int STAMP_BITS = aclr_pkg::STAMP_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // key, entry_data
    input  logic [((KEY_BITS + DATA_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // command
    input  logic [0:0]  i_s_axis_tuser,
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // found_data, slot, evicted_key, evicted_data
    output logic [((2 * DATA_BITS + KEY_BITS + aclr_pkg::SLOT_BITS + 7) / 8) * 8 - 1:0]
                        o_m_axis_tdata,
    // hit, evicted
    output logic [1:0]  o_m_axis_tuser,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import aclr_pkg::*;

    localparam int IW     = $clog2(WAYS);
    localparam int OUT_DW = 2 * DATA_BITS + KEY_BITS + SLOT_BITS;
    localparam int OUT_TW = ((OUT_DW + 7) / 8) * 8;
    localparam logic [IW-1:0]         LAST_WAY  = IW'(WAYS - 1);
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};

    function automatic logic [SLOT_BITS-1:0] slot_field(input logic [IW-1:0] idx);
        logic [IW+SLOT_BITS-1:0] ext;
        ext = (IW + SLOT_BITS)'(idx);
        return ext[SLOT_BITS-1:0];
    endfunction

    // Slot storage
    logic [KEY_BITS-1:0]   r_mem_key   [WAYS];
    logic [DATA_BITS-1:0]  r_mem_data  [WAYS];
    logic [STAMP_BITS-1:0] r_mem_stamp [WAYS];
    logic [WAYS-1:0]       r_valid;
    logic [STAMP_BITS-1:0] r_clock;

    // Registers
    logic                  r_policy;
    logic [SEED_BITS-1:0]  r_seed;

    // Sequencer and item
    t_state                r_state;
    t_state                n_state;
    logic                  r_cmd;
    logic [KEY_BITS-1:0]   r_key;
    logic [DATA_BITS-1:0]  r_data;

    // Scan pipeline
    logic [IW-1:0]         r_addr;
    logic                  r_issue;
    logic                  r_rdv;
    logic [IW-1:0]         r_rd_idx;
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [DATA_BITS-1:0]  r_rd_data;
    logic [STAMP_BITS-1:0] r_rd_stamp;
    logic [IW-1:0]         rd_addr;

    // Scan results
    logic                  r_found;
    logic [IW-1:0]         r_target;
    logic [DATA_BITS-1:0]  r_hit_data;
    logic [IW-1:0]         r_best;
    logic [STAMP_BITS-1:0] r_best_stamp;
    logic                  r_evict;

    // Output register
    logic                  r_out_valid;
    logic [OUT_TW-1:0]     r_out_tdata;
    logic [1:0]            r_out_tuser;

    // Strobes
    logic                  in_xfer;
    logic                  cfg_we;
    logic                  cur_match;
    logic                  scan_last;
    logic                  pick_victim;
    logic                  do_update;
    logic                  hit;
    logic                  slot_write;
    logic [STAMP_BITS-1:0] stamp_next;
    logic [IW-1:0]         vic_pick;
    logic                  vic_busy;
    t_victim_ctrl          vic_ctrl;

    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_we  = psel && penable && pwrite && pready;

    // Victim generator and its modulo unit
    aclr_victim #(
        .WAYS(WAYS)
    ) u_victim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (vic_ctrl),
        .i_seed  (pwdata[SEED_BITS-1:0]),
        .o_busy  (vic_busy),
        .o_pick  (vic_pick)
    );

    // Compare the slot read last cycle
    always_comb begin
        cur_match = 1'b0;
        if (r_rdv && !r_found) begin
            if (r_cmd == CMD_LOOKUP) begin
                cur_match = r_valid[r_rd_idx] && (r_rd_key == r_key);
            end else begin
                cur_match = !r_valid[r_rd_idx];
            end
        end
        scan_last = r_rdv && (r_rd_idx == LAST_WAY);
    end

    // Next state and strobes
    always_comb begin
        n_state            = r_state;
        o_s_axis_tready    = 1'b0;
        pick_victim        = 1'b0;
        do_update          = 1'b0;
        vic_ctrl.seed_load = cfg_we && (paddr[2] == REG_SEED);
        vic_ctrl.start     = 1'b0;
        vic_ctrl.step      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                vic_ctrl.start  = i_s_axis_tvalid;
                if (i_s_axis_tvalid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    if (r_cmd == CMD_LOOKUP || r_found || cur_match) begin
                        n_state = ST_UPDATE;
                    end else begin
                        n_state = ST_VICTIM;
                    end
                end
            end
            ST_VICTIM: begin
                if (r_policy == POLICY_LRU || !vic_busy) begin
                    pick_victim   = 1'b1;
                    vic_ctrl.step = (r_policy == POLICY_RANDOM);
                    n_state       = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    do_update = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Registers: written with byte lanes aligned, index on address bit 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POLICY_LRU;
            r_seed   <= LFSR_RESET;
        end else if (cfg_we) begin
            unique case (paddr[2])
                REG_POLICY: r_policy <= pwdata[0];
                REG_SEED:   r_seed   <= pwdata[SEED_BITS-1:0];
                default:    r_policy <= r_policy;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_POLICY: prdata = 32'(r_policy);
            REG_SEED:   prdata = 32'(r_seed);
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Read one slot per cycle while scanning, else the chosen target
    assign rd_addr = (r_state == ST_SCAN) ? r_addr : r_target;

    always_ff @(posedge i_clk) begin
        r_rd_key   <= r_mem_key[rd_addr];
        r_rd_data  <= r_mem_data[rd_addr];
        r_rd_stamp <= r_mem_stamp[rd_addr];
    end

    // Scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_rdv   <= 1'b0;
            r_found <= 1'b0;
            r_evict <= 1'b0;
        end else if (in_xfer) begin
            r_issue <= 1'b1;
            r_rdv   <= 1'b0;
            r_found <= 1'b0;
            r_evict <= 1'b0;
        end else begin
            r_rdv <= r_issue;
            if (r_issue && r_addr == LAST_WAY) begin
                r_issue <= 1'b0;
            end
            if (cur_match) begin
                r_found <= 1'b1;
            end
            if (pick_victim) begin
                r_evict <= 1'b1;
            end
        end
    end

    // Scan datapath: latch the item, step the address, track match and oldest stamp
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd  <= i_s_axis_tuser[0];
            r_key  <= i_s_axis_tdata[KEY_BITS-1:0];
            r_data <= i_s_axis_tdata[KEY_BITS +: DATA_BITS];
            r_addr <= '0;
        end else begin
            if (r_issue && r_addr != LAST_WAY) begin
                r_addr <= r_addr + 1'b1;
            end
            r_rd_idx <= r_addr;
            if (cur_match) begin
                r_target   <= r_rd_idx;
                r_hit_data <= r_rd_data;
            end
            if (r_rdv && (r_rd_idx == '0 || r_rd_stamp < r_best_stamp)) begin
                r_best       <= r_rd_idx;
                r_best_stamp <= r_rd_stamp;
            end
            if (pick_victim) begin
                r_target <= (r_policy == POLICY_RANDOM) ? vic_pick : r_best;
            end
        end
    end

    // Update: bump the saturating clock and write the touched slot
    assign hit        = (r_cmd == CMD_LOOKUP) && r_found;
    assign slot_write = (r_cmd == CMD_INSERT) || r_found;
    assign stamp_next = (r_clock == STAMP_MAX) ? r_clock : r_clock + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock <= '0;
            r_valid <= '0;
        end else if (do_update && slot_write) begin
            r_clock <= stamp_next;
            if (r_cmd == CMD_INSERT) begin
                r_valid[r_target] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_update && slot_write) begin
            r_mem_stamp[r_target] <= stamp_next;
            if (r_cmd == CMD_INSERT) begin
                r_mem_key[r_target]  <= r_key;
                r_mem_data[r_target] <= r_data;
            end
        end
    end

    // Output register: load the result, drop it after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_update) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_update) begin
            r_out_tuser <= {r_evict, hit};
            r_out_tdata <= OUT_TW'({
                r_evict ? r_rd_data : {DATA_BITS{1'b0}},
                r_evict ? r_rd_key : {KEY_BITS{1'b0}},
                slot_write ? slot_field(r_target) : {SLOT_BITS{1'b0}},
                hit ? r_hit_data : {DATA_BITS{1'b0}}
            });
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;
    assign o_m_axis_tuser  = r_out_tuser;

`ifndef SYNTHESIS
    // A new item starts its scan with no match carried over
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == ST_SCAN) && !r_found && !r_evict)
        else $error("scan did not start clean");

    // An insert that found no empty slot must replace a victim
    a_full_evicts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE && r_cmd == CMD_INSERT && !r_found) |-> r_evict)
        else $error("insert into full cache without eviction");

    // Valid bits only ever set until reset
    a_valid_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_valid & $past(r_valid)) == $past(r_valid)))
        else $error("slot lost its valid bit");

    // A random victim is taken only once the modulo unit has finished
    a_pick_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pick_victim && r_policy == POLICY_RANDOM) |-> !vic_busy && !r_found)
        else $error("random victim picked early");
`endif

endmodule

// ===== tb/tb_assoc_cache_lru_random.sv =====
`timescale 1ns / 1ps

module tb_assoc_cache_lru_random;

    import aclr_pkg::*;

    localparam int WAYS   = WAYS_DEF;
    localparam int KEY_W  = KEY_BITS_DEF;
    localparam int DATA_W = DATA_BITS_DEF;
    localparam int STAMP_W = STAMP_BITS_DEF;
    localparam int IN_W   = ((KEY_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_W  = ((2 * DATA_W + KEY_W + SLOT_BITS + 7) / 8) * 8;

    // Idle cycles after a drain, before register writes
    localparam int SETTLE_CYCLES = 30;

    typedef struct packed {
        logic                 hit;
        logic [DATA_W-1:0]    found_data;
        logic [SLOT_BITS-1:0] slot;
        logic                 evicted;
        logic [KEY_W-1:0]     evicted_key;
        logic [DATA_W-1:0]    evicted_data;
    } t_cache_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [IN_W-1:0]   i_s_axis_tdata = '0;     // key, entry_data
    logic [0:0]        i_s_axis_tuser = '0;     // command
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  o_m_axis_tdata;          // found_data, slot, evicted_key, evicted_data
    logic [1:0]        o_m_axis_tuser;          // hit, evicted
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    assoc_cache_lru_random dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Mirror of the cache contents and victim selection state
    logic                 way_valid   [WAYS];
    logic [KEY_W-1:0]     way_key     [WAYS];
    logic [DATA_W-1:0]    way_payload [WAYS];
    logic [STAMP_W-1:0]   way_stamp   [WAYS];
    logic [STAMP_W-1:0]   access_clock;
    logic [SEED_BITS-1:0] victim_lfsr;
    logic                 policy;

    t_cache_result pending_results[$];
    int mismatch_count = 0;
    int report_count = 0;

    // Sender burst control
    int  burst_left = 0;
    bit  sender_gaps = 1'b1;

    // Receiver stall pattern
    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_age = 0;

    function automatic logic [STAMP_W-1:0] bump_access_clock();
        if (access_clock != '1)
            access_clock = access_clock + 1'b1;
        return access_clock;
    endfunction

    // Apply one command to the mirror and return the result it must produce
    function automatic t_cache_result predict_cache_access(logic cmd, logic [KEY_W-1:0] key,
                                                          logic [DATA_W-1:0] data);
        t_cache_result r;
        int way;
        bit found;
        bit low;
        r = '0;
        way = 0;
        found = 1'b0;
        if (cmd == CMD_LOOKUP) begin
            for (int w = 0; w < WAYS; w++) begin
                if (!found && way_valid[w] && way_key[w] == key) begin
                    way = w;
                    found = 1'b1;
                end
            end
            if (found) begin
                way_stamp[way] = bump_access_clock();
                r.hit = 1'b1;
                r.found_data = way_payload[way];
                r.slot = way[SLOT_BITS-1:0];
            end
            return r;
        end
        // insert: lowest empty slot first
        for (int w = 0; w < WAYS; w++) begin
            if (!found && !way_valid[w]) begin
                way = w;
                found = 1'b1;
            end
        end
        if (!found) begin
            if (policy == POLICY_RANDOM) begin
                way = victim_lfsr % WAYS;
                low = victim_lfsr[0];
                victim_lfsr = victim_lfsr >> 1;
                if (low)
                    victim_lfsr = victim_lfsr ^ LFSR_TAPS;
            end else begin
                way = 0;
                for (int w = 1; w < WAYS; w++)
                    if (way_stamp[w] < way_stamp[way])
                        way = w;
            end
            r.evicted = 1'b1;
            r.evicted_key = way_key[way];
            r.evicted_data = way_payload[way];
        end
        way_valid[way] = 1'b1;
        way_key[way] = key;
        way_payload[way] = data;
        way_stamp[way] = bump_access_clock();
        r.slot = way[SLOT_BITS-1:0];
        return r;
    endfunction

    function automatic void report_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (report_count < 200) begin
                report_count++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        end
    endfunction

    // Compare one accepted result transfer with the oldest expectation
    task automatic check_result();
        t_cache_result want;
        t_cache_result got;
        got.found_data   = o_m_axis_tdata[DATA_W-1:0];
        got.slot         = o_m_axis_tdata[DATA_W +: SLOT_BITS];
        got.evicted_key  = o_m_axis_tdata[DATA_W + SLOT_BITS +: KEY_W];
        got.evicted_data = o_m_axis_tdata[DATA_W + SLOT_BITS + KEY_W +: DATA_W];
        got.hit          = o_m_axis_tuser[0];
        got.evicted      = o_m_axis_tuser[1];
        if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with none expected, expected none, actual %h", $time, got);
            return;
        end
        want = pending_results.pop_front();
        report_field("hit", want.hit, got.hit);
        report_field("found_data", want.found_data, got.found_data);
        report_field("slot", want.slot, got.slot);
        report_field("evicted", want.evicted, got.evicted);
        report_field("evicted_key", want.evicted_key, got.evicted_key);
        report_field("evicted_data", want.evicted_data, got.evicted_data);
    endtask

    // Check result transfers and stall the result stream on a rotating pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            check_result();
        if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pattern = 16'hFFFF;
                1: ready_pattern = 16'($urandom);
                2: ready_pattern = 16'($urandom & $urandom);
                default: ready_pattern = 16'($urandom | $urandom);
            endcase
            if (ready_pattern == '0)
                ready_pattern = 16'h0001;
            pattern_age = 48;
        end
        pattern_age--;
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
        i_m_axis_tready <= ready_pattern[0];
    end

    // Send one command; valid stays high after the transfer until a gap or a drain
    task automatic send_item(logic cmd, logic [KEY_W-1:0] key, logic [DATA_W-1:0] data);
        if (sender_gaps && burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_W'({data, key});
        i_s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(predict_cache_access(cmd, key, data));
    endtask

    // Drop valid and wait until every expected result has arrived and the block settles
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_POLICY) begin
            policy = value[0];
        end else begin
            victim_lfsr = (value[SEED_BITS-1:0] != '0) ? value[SEED_BITS-1:0] : LFSR_RESET;
        end
    endtask

    // Empty cache, fill with extreme keys and a duplicate, hits, misses, LRU eviction
    task automatic test_directed_lru();
        send_item(CMD_LOOKUP, 32'h0000_0000, 32'h1111_1111);
        send_item(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(CMD_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_item(CMD_INSERT, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        send_item(CMD_INSERT, 32'hA5A5_A5A5, 32'h0000_0001);
        send_item(CMD_INSERT, 32'h0000_0001, 32'h8000_0000);
        send_item(CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(CMD_INSERT, 32'h7FFF_FFFF, 32'h0000_0001);
        send_item(CMD_LOOKUP, 32'hA5A5_A5A5, 32'hFFFF_FFFF);
        send_item(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_item(CMD_LOOKUP, 32'hDEAD_BEEF, 32'h0000_0000);
        send_item(CMD_INSERT, 32'h1234_5678, 32'h9ABC_DEF0);
        send_item(CMD_INSERT, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
        drain();
    endtask

    // Random victims from the reset seed substitute and from the all-ones seed
    task automatic test_directed_random();
        write_reg(REG_POLICY, 32'h0000_0001);
        write_reg(REG_SEED, 32'h0000_0000);
        send_item(CMD_INSERT, 32'hCAFE_0001, 32'h0000_0101);
        send_item(CMD_INSERT, 32'hCAFE_0002, 32'h0000_0202);
        send_item(CMD_INSERT, 32'hCAFE_0003, 32'h0000_0303);
        send_item(CMD_LOOKUP, 32'hCAFE_0002, 32'h0000_0000);
        drain();
        write_reg(REG_SEED, 32'hABCD_FFFF);
        send_item(CMD_INSERT, 32'hCAFE_0004, 32'h0000_0404);
        send_item(CMD_INSERT, 32'hCAFE_0005, 32'h0000_0505);
        send_item(CMD_INSERT, 32'hCAFE_0006, 32'h0000_0606);
        drain();
    endtask

    // Phases of random traffic over small key pools, with policy and seed changed between them
    task automatic test_random_traffic(int phases, int items_per_phase);
        logic [KEY_W-1:0] key_pool [16];
        logic [KEY_W-1:0] key;
        logic [15:0]      seed;
        logic             cmd;
        int               pool_n;
        for (int p = 0; p < phases; p++) begin
            case (p)
                1: seed = 16'hFFFF;
                3: seed = 16'h0000;
                5: seed = 16'h0001;
                default: seed = 16'($urandom_range(1, 65535));
            endcase
            write_reg(REG_POLICY, ($urandom & ~32'h1) |
                      32'((p % 2 == 1) ? POLICY_RANDOM : POLICY_LRU));
            write_reg(REG_SEED, {16'($urandom), seed});
            sender_gaps = !(p == 2 || p == 7);
            pool_n = $urandom_range(4, 16);
            for (int k = 0; k < 16; k++)
                key_pool[k] = $urandom;
            for (int i = 0; i < items_per_phase; i++) begin
                if ($urandom_range(0, 9) < 7)
                    key = key_pool[$urandom_range(0, pool_n - 1)];
                else
                    key = $urandom;
                cmd = ($urandom_range(0, 99) < 55) ? CMD_LOOKUP : CMD_INSERT;
                send_item(cmd, key, $urandom);
            end
            drain();
        end
    endtask

    initial begin
        for (int w = 0; w < WAYS; w++) begin
            way_valid[w] = 1'b0;
            way_key[w] = '0;
            way_payload[w] = '0;
            way_stamp[w] = '0;
        end
        access_clock = '0;
        victim_lfsr = LFSR_RESET;
        policy = POLICY_LRU;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_lru();
        test_directed_random();
        test_random_traffic(10, 113);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb_assoc_cache_lru_random: done, clean");
        end else begin
            $display("tb_assoc_cache_lru_random: done, errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_assoc_cache_lru_random: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/aclr_pkg.sv
hw/rtl/aclr_victim.sv
hw/rtl/assoc_cache_lru_random.sv
tb/tb_assoc_cache_lru_random.sv
